### hw/rtl/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg
// shared types and constants of the per-pixel sigma-clipped running mean
// ----------------------------------------------------------------------------
package pscm_pkg;

	localparam int PIXEL_COUNT = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int IDX_W       = 12;
	localparam int NUM_W       = 33;
	localparam int DIV_STAGES  = NUM_W;
	localparam int Q_DEPTH     = 2;
	localparam int QP_W        = 1;

	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [3:0]  CLIP_RESET   = 4'd3;
	localparam logic [7:0]  WARMUP_RESET = 8'd5;
	localparam logic [15:0] SAMPLE_MASK  =
		(SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

	typedef enum logic [0:0] {
		REG_CLIP   = 1'b0,
		REG_WARMUP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [15:0]      sample_value;
	} in_t;

	typedef struct packed {
		logic [31:0] mean_out;
		logic [15:0] count_out;
		logic        accepted;
	} out_t;

	typedef struct packed {
		logic [15:0] count;
		logic [31:0] mean;
		logic [63:0] m2;
	} mem_t;

	localparam int MEM_W = $bits(mem_t);

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		mem_t              data;
	} wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             in_range;
		logic             ok;
		logic             neg;
		logic [31:0]      abs_d;
		logic [31:0]      vq;
		logic [31:0]      mean;
		logic [15:0]      n;
		logic [63:0]      m2;
	} work_t;

	typedef struct packed {
		work_t            w;
		logic [15:0]      dvs;
		logic [NUM_W-1:0] num;
		logic [15:0]      rem;
		logic [31:0]      quo;
	} div_t;

endpackage

### hw/rtl/pscm_ram.sv
// ----------------------------------------------------------------------------
// pscm_ram
// generic single write port memory with registered read
// ----------------------------------------------------------------------------
module pscm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/pscm_front.sv
// ----------------------------------------------------------------------------
// pscm_front
// accepts beats, reads pixel state, runs the outlier test, clears memory
// ----------------------------------------------------------------------------
module pscm_front
	import pscm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_t               item,
	input  logic [3:0]        clip_factor,
	input  logic [7:0]        warmup_count,
	input  logic              ext_hit,
	output logic [ADDR_W-1:0] rd_addr,
	input  mem_t              rd_data,
	output wr_t               clr_wr,
	output logic              push,
	output work_t             push_work
);

	logic              accept;
	logic              hit_local;
	logic              clr_act;
	logic [ADDR_W:0]   clr_q;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic [IDX_W-1:0]  idx_s1;
	logic [15:0]       v_s1;
	work_t             w_s1, w_s2, w_s3, w_s4;
	logic [63:0]       d2_s3;
	logic [71:0]       rhs_s3, rhs_s4;
	logic [79:0]       lhs_s4;
	logic              d2nz_s4;
	logic [7:0]        c2;
	logic              outlier;

	assign clr_act = clr_q < (ADDR_W+1)'(PIXEL_COUNT);
	assign accept  = start && !busy;
	assign busy    = clr_act || hit_local || ext_hit;
	assign rd_addr = ADDR_W'(item.pixel_index);
	assign c2      = {4'b0, clip_factor} * {4'b0, clip_factor};

	assign clr_wr.en   = clr_act;
	assign clr_wr.addr = clr_q[ADDR_W-1:0];
	assign clr_wr.data = '0;

	always_comb begin
		hit_local = (vld_s1 && idx_s1 == item.pixel_index) ||
			(vld_s2 && w_s2.idx == item.pixel_index) ||
			(vld_s3 && w_s3.idx == item.pixel_index) ||
			(vld_s4 && w_s4.idx == item.pixel_index);
	end

	// fields of the beat once memory data is back
	always_comb begin
		w_s1          = '0;
		w_s1.idx      = idx_s1;
		w_s1.in_range = 32'(idx_s1) < 32'(PIXEL_COUNT);
		w_s1.vq       = {v_s1, 16'b0};
		w_s1.mean     = rd_data.mean;
		w_s1.n        = rd_data.count;
		w_s1.m2       = rd_data.m2;
		w_s1.neg      = w_s1.vq < rd_data.mean;
		w_s1.abs_d    = w_s1.neg ? rd_data.mean - w_s1.vq : w_s1.vq - rd_data.mean;
	end

	always_comb begin
		if (w_s4.n <= 16'd1) begin
			outlier = d2nz_s4;
		end else begin
			outlier = {8'b0, lhs_s4} > {rhs_s4, 16'b0};
		end
		push_work = w_s4;
		push_work.ok = w_s4.in_range && (w_s4.n < COUNT_MAX) &&
			!((w_s4.n > {8'b0, warmup_count}) && outlier);
	end

	assign push = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (clr_act) begin
				clr_q <= clr_q + (ADDR_W+1)'(1);
			end
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= item.pixel_index;
		v_s1    <= item.sample_value & SAMPLE_MASK;
		w_s2    <= w_s1;
		w_s3    <= w_s2;
		d2_s3   <= 64'(w_s2.abs_d) * 64'(w_s2.abs_d);
		rhs_s3  <= 72'(w_s2.m2) * 72'(c2);
		w_s4    <= w_s3;
		lhs_s4  <= 80'(d2_s3) * 80'(w_s3.n - 16'd1);
		rhs_s4  <= rhs_s3;
		d2nz_s4 <= d2_s3 != 64'd0;
	end

endmodule

### hw/rtl/pscm_queue.sv
// ----------------------------------------------------------------------------
// pscm_queue
// short queue between the classifying front and the update back end
// ----------------------------------------------------------------------------
module pscm_queue
	import pscm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  work_t            push_work,
	input  logic [IDX_W-1:0] probe_idx,
	output logic             hit,
	output logic             out_valid,
	output work_t            out_work
);

	work_t              slot_q [Q_DEPTH];
	logic [Q_DEPTH-1:0] vld_q;
	logic [Q_DEPTH-1:0] vld_nxt;
	logic [QP_W-1:0]    wptr_q, rptr_q;

	assign out_valid = vld_q[rptr_q];
	assign out_work  = slot_q[rptr_q];

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < Q_DEPTH; k++) begin
			if (vld_q[k] && slot_q[k].idx == probe_idx) begin
				hit = 1'b1;
			end
		end
	end

	always_comb begin
		vld_nxt = vld_q;
		if (out_valid) begin
			vld_nxt[rptr_q] = 1'b0;
		end
		if (push) begin
			vld_nxt[wptr_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			vld_q <= vld_nxt;
			if (push) begin
				wptr_q <= wptr_q + QP_W'(1);
			end
			if (out_valid) begin
				rptr_q <= rptr_q + QP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_work;
		end
	end

endmodule

### hw/rtl/pscm_back.sv
// ----------------------------------------------------------------------------
// pscm_back
// pipelined mean division, deviation sum update, write back and result
// ----------------------------------------------------------------------------
module pscm_back
	import pscm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  work_t            in_work,
	input  logic [IDX_W-1:0] probe_idx,
	output logic             hit,
	output wr_t              wr,
	output logic             done,
	output out_t             result
);

	function automatic div_t div_step(div_t d);
		div_t        r;
		logic [16:0] t;
		r     = d;
		t     = {d.rem, d.num[NUM_W-1]};
		r.num = d.num << 1;
		if (t >= {1'b0, d.dvs}) begin
			r.rem = 16'(t - {1'b0, d.dvs});
			r.quo = {d.quo[30:0], 1'b1};
		end else begin
			r.rem = t[15:0];
			r.quo = {d.quo[30:0], 1'b0};
		end
		return r;
	endfunction

	div_t                  div_init;
	div_t                  div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_vld_s;
	div_t                  div_last;

	logic        vld_s1, vld_s2;
	work_t       w_s1, w_s2;
	logic [31:0] mean2_s1, mean2_s2, absd2_s1;
	logic [63:0] prod_s2;
	logic [31:0] mean2, absd2;
	logic [48:0] inc;
	logic [64:0] sum;
	logic [63:0] m2_new;
	logic [15:0] nn_s2;
	logic        done_q;
	out_t        res_q;
	out_t        res_nxt;

	always_comb begin
		div_init     = '0;
		div_init.w   = in_work;
		div_init.dvs = in_work.n + 16'd1;
		div_init.num = {1'b0, in_work.abs_d} + NUM_W'(div_init.dvs >> 1);
	end

	assign div_last = div_s[DIV_STAGES-1];

	always_comb begin
		mean2 = div_last.w.neg ? div_last.w.mean - div_last.quo
		                       : div_last.w.mean + div_last.quo;
		absd2 = div_last.w.neg ? mean2 - div_last.w.vq : div_last.w.vq - mean2;
	end

	always_comb begin
		hit = (vld_s1 && w_s1.idx == probe_idx) || (vld_s2 && w_s2.idx == probe_idx);
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (div_vld_s[k] && div_s[k].w.idx == probe_idx) begin
				hit = 1'b1;
			end
		end
	end

	// rounded increment and saturating sum
	always_comb begin
		inc    = {1'b0, prod_s2[63:16]} + 49'(prod_s2[15]);
		sum    = {1'b0, w_s2.m2} + {16'b0, inc};
		m2_new = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
		nn_s2  = w_s2.n + 16'd1;
	end

	always_comb begin
		wr.en         = vld_s2 && w_s2.ok;
		wr.addr       = ADDR_W'(w_s2.idx);
		wr.data.count = nn_s2;
		wr.data.mean  = mean2_s2;
		wr.data.m2    = m2_new;
	end

	always_comb begin
		if (!w_s2.in_range) begin
			res_nxt = '0;
		end else if (w_s2.ok) begin
			res_nxt.mean_out  = mean2_s2;
			res_nxt.count_out = nn_s2;
			res_nxt.accepted  = 1'b1;
		end else begin
			res_nxt.mean_out  = w_s2.mean;
			res_nxt.count_out = w_s2.n;
			res_nxt.accepted  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			div_vld_s <= {div_vld_s[DIV_STAGES-2:0], in_valid};
			vld_s1    <= div_vld_s[DIV_STAGES-1];
			vld_s2    <= vld_s1;
			done_q    <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= div_step(div_init);
		for (int k = 1; k < DIV_STAGES; k++) begin
			div_s[k] <= div_step(div_s[k-1]);
		end
		w_s1     <= div_last.w;
		mean2_s1 <= mean2;
		absd2_s1 <= absd2;
		w_s2     <= w_s1;
		mean2_s2 <= mean2_s1;
		prod_s2  <= 64'(w_s1.abs_d) * 64'(absd2_s1);
		res_q    <= res_nxt;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### hw/rtl/pixel_sigma_clipped_running_mean_top.sv
// ----------------------------------------------------------------------------
// pixel_sigma_clipped_running_mean_top
// per-pixel running mean with sigma clipping, register port and memory
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, every stage including the 33-stage mean
// divider is pipelined; a beat for a pixel still in flight waits until its
// write back is done
// reset: busy stays high while the pixel memory is cleared
// the receiver cannot stall, results leave on a one-cycle strobe
module pixel_sigma_clipped_running_mean_top
	import pscm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         item,
	output logic        done,
	output out_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0]        clip_q;
	logic [7:0]        warm_q;
	reg_idx_t          reg_sel;
	logic              cfg_we;

	logic [ADDR_W-1:0] rd_addr;
	logic [MEM_W-1:0]  rd_raw;
	mem_t              rd_data;
	wr_t               clr_wr, back_wr, mem_wr;
	logic              push;
	work_t             push_work;
	logic              q_valid;
	work_t             q_work;
	logic              q_hit, b_hit;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_CLIP:   prdata = {28'b0, clip_q};
			REG_WARMUP: prdata = {24'b0, warm_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= CLIP_RESET;
			warm_q <= WARMUP_RESET;
		end else if (cfg_we) begin
			case (reg_sel)
				REG_CLIP:   clip_q <= pwdata[3:0];
				REG_WARMUP: warm_q <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	assign mem_wr  = clr_wr.en ? clr_wr : back_wr;
	assign rd_data = mem_t'(rd_raw);

	pscm_ram #(
		.WIDTH(MEM_W),
		.DEPTH(PIXEL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (mem_wr.en),
		.waddr(mem_wr.addr),
		.wdata(mem_wr.data),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	pscm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.clip_factor (clip_q),
		.warmup_count(warm_q),
		.ext_hit     (q_hit || b_hit),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.clr_wr      (clr_wr),
		.push        (push),
		.push_work   (push_work)
	);

	pscm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_work(push_work),
		.probe_idx(item.pixel_index),
		.hit      (q_hit),
		.out_valid(q_valid),
		.out_work (q_work)
	);

	pscm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_work  (q_work),
		.probe_idx(item.pixel_index),
		.hit      (b_hit),
		.wr       (back_wr),
		.done     (done),
		.result   (result)
	);

endmodule
